// File: hw/rtl/gawt_pkg.sv
// Shared constants and defaults for the global alignment block.
`default_nettype none
package gawt_pkg;

   localparam int MAX_ROWS_DEF    = 32;
   localparam int MAX_COLS_DEF    = 32;
   localparam int SCORE_WIDTH_DEF = 16;

   localparam int VAL_W     = 23;
   localparam int PEN_W     = 15;
   localparam int SIZE_W    = 6;
   localparam int IDX_W     = 6;
   localparam int OUT_IDX_W = 5;
   localparam int MATCH_W   = 6;
   localparam int SKIP_W    = 7;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   localparam logic [1:0] REG_INDEL_PENALTY  = 2'd0;
   localparam logic [1:0] REG_ROWS_USED      = 2'd1;
   localparam logic [1:0] REG_COLS_USED      = 2'd2;
   localparam logic [1:0] REG_REVERSE_STRAND = 2'd3;

   localparam logic STRAND_SAME = 1'b0;
   localparam logic STRAND_DIFF = 1'b1;

   localparam logic [PEN_W-1:0]  PEN_RESET  = 15'd256;
   localparam logic [SIZE_W-1:0] ROWS_RESET = 6'd32;
   localparam logic [SIZE_W-1:0] COLS_RESET = 6'd32;

   localparam logic [1:0] DIR_MATCH = 2'd0;
   localparam logic [1:0] DIR_UP    = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;

endpackage
`default_nettype wire

// File: hw/rtl/global_alignment_with_traceback.sv
// Top level of the global alignment table fill and traceback engine.
//
// Usage: program indel_penalty, rows_used, cols_used and reverse_strand over the
// APB-style port while the block is idle. Then hand in the similarity matrix in
// row-major order, one score per beat: a beat is taken when start is high and
// busy is low. Each cell runs through one shared saturating adder, in order:
// gap from left, diagonal, gap from above, then the compare. The first cell of
// an alignment first sweeps the first table row into the row buffer. After the
// last cell the traceback walks the direction memory (at most rows_used+cols_used
// steps), then each matched pair leaves as one result beat, in forward order,
// held for exactly one cycle and marked by rsp_strobe; rsp_last marks the final
// beat. With no matches one beat with rsp_dot_valid low is sent. The receiver
// cannot stall the result side.
// Reset restores the register defaults and returns the sequencer to idle; the
// row buffer, direction memory and pair stack are not cleared.
`default_nettype none
module global_alignment_with_traceback
   import gawt_pkg::*;
#(
   parameter int MAX_ROWS    = MAX_ROWS_DEF,
   parameter int MAX_COLS    = MAX_COLS_DEF,
   parameter int SCORE_WIDTH = SCORE_WIDTH_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire signed [SCORE_WIDTH-1:0] req_score,
   output logic                         rsp_strobe,
   output logic                         rsp_dot_valid,
   output logic [OUT_IDX_W-1:0]         rsp_row_index,
   output logic [OUT_IDX_W-1:0]         rsp_col_index,
   output logic                         rsp_last,
   output logic [MATCH_W-1:0]           rsp_match_count,
   output logic [SKIP_W-1:0]            rsp_skip_count,
   output logic signed [VAL_W-1:0]      rsp_final_score,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire [CSR_AW-1:0]             paddr,
   input  wire [CSR_DW-1:0]             pwdata,
   output logic [CSR_DW-1:0]            prdata,
   output logic                         pready
);

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int ER    = $clog2(MAX_ROWS + 1);
   localparam int EC    = $clog2(MAX_COLS + 1);
   localparam int DA    = $clog2(MAX_ROWS * MAX_COLS);
   localparam int SUM_W = ((SCORE_WIDTH > VAL_W) ? SCORE_WIDTH : VAL_W) + 1;
   localparam logic signed [SUM_W-1:0] SUM_HI =
      {{(SUM_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_LO =
      {{(SUM_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_CELL_A, ST_CELL_B, ST_CELL_C, ST_CELL_D,
      ST_TB_CHK, ST_TB_DIR, ST_EMIT_RD, ST_EMIT_OUT
   } state_type;

   state_type state_ff;

   logic [PEN_W-1:0]  pen_ff;
   logic [SIZE_W-1:0] rows_cfg_ff;
   logic [SIZE_W-1:0] cols_cfg_ff;
   logic              strand_ff;

   logic [RW-1:0]      row_ff;
   logic [CW-1:0]      col_ff;
   logic [MATCH_W-1:0] match_ff;
   logic [SKIP_W-1:0]  skip_ff;
   logic [EC-1:0]      init_j_ff;
   logic [ER-1:0]      tb_i_ff;
   logic [EC-1:0]      tb_j_ff;
   logic [ER-1:0]      n_ff;
   logic [RW-1:0]      p_ff;

   logic signed [SCORE_WIDTH-1:0] score_ff;
   logic signed [VAL_W-1:0]       left_ff;
   logic signed [VAL_W-1:0]       init_val_ff;
   logic signed [VAL_W-1:0]       c1_ff;
   logic signed [VAL_W-1:0]       c2_ff;
   logic signed [VAL_W-1:0]       c3_ff;
   logic signed [VAL_W-1:0]       final_ff;

   logic signed [VAL_W-1:0] prev_mem [0:MAX_COLS];
   logic [1:0]              dir_mem [0:MAX_ROWS*MAX_COLS-1];
   logic [2*IDX_W-1:0]      stack_mem [0:MAX_ROWS-1];
   logic signed [VAL_W-1:0] prev_rd_ff;
   logic [1:0]              dir_rd_ff;
   logic [2*IDX_W-1:0]      stack_rd_ff;

   logic [ER-1:0] rows_eff;
   logic [EC-1:0] cols_eff;
   logic          accept;
   logic          cfg_write;
   logic          col_end;
   logic          row_last;

   logic [VAL_W-2:0]        left_prod;
   logic signed [VAL_W-1:0] left_in;
   logic signed [VAL_W:0]   neg_pen;
   logic signed [SUM_W-1:0] alu_a;
   logic signed [SUM_W-1:0] alu_b;
   logic signed [SUM_W-1:0] alu_sum;
   logic signed [VAL_W-1:0] alu_in;
   logic signed [VAL_W-1:0] best_in;
   logic [1:0]              dir_in;

   logic                    prev_we;
   logic [EC-1:0]           prev_wa;
   logic signed [VAL_W-1:0] prev_wd;
   logic [EC-1:0]           prev_ra;
   logic [DA-1:0]           dir_wa;
   logic [DA-1:0]           dir_ra;
   logic [2*IDX_W-1:0]      push_in;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      if (rows_cfg_ff == '0) begin
         rows_eff = ER'(1);
      end else if (int'(rows_cfg_ff) > MAX_ROWS) begin
         rows_eff = ER'(MAX_ROWS);
      end else begin
         rows_eff = ER'(rows_cfg_ff);
      end
      if (cols_cfg_ff == '0) begin
         cols_eff = EC'(1);
      end else if (int'(cols_cfg_ff) > MAX_COLS) begin
         cols_eff = EC'(MAX_COLS);
      end else begin
         cols_eff = EC'(cols_cfg_ff);
      end
   end

   assign col_end  = (EC'(col_ff) + EC'(1)) >= cols_eff;
   assign row_last = (ER'(row_ff) + ER'(1)) >= rows_eff;

   always_comb begin
      case (paddr[3:2])
         REG_INDEL_PENALTY:  prdata = CSR_DW'(pen_ff);
         REG_ROWS_USED:      prdata = CSR_DW'(rows_cfg_ff);
         REG_COLS_USED:      prdata = CSR_DW'(cols_cfg_ff);
         REG_REVERSE_STRAND: prdata = CSR_DW'(strand_ff);
         default:            prdata = '0;
      endcase
   end

   // first table column value for the row being entered
   assign left_prod = (VAL_W-1)'(ER'(row_ff) + ER'(1)) * (VAL_W-1)'(pen_ff);
   assign left_in   = -$signed({1'b0, left_prod});
   assign neg_pen   = -$signed({{(VAL_W - PEN_W + 1){1'b0}}, pen_ff});

   always_comb begin
      case (state_ff)
         ST_INIT: begin
            alu_a = SUM_W'(init_val_ff);
            alu_b = SUM_W'(neg_pen);
         end
         ST_CELL_A: begin
            alu_a = SUM_W'(left_ff);
            alu_b = SUM_W'(neg_pen);
         end
         ST_CELL_B: begin
            alu_a = SUM_W'(prev_rd_ff);
            alu_b = SUM_W'(score_ff);
         end
         default: begin
            alu_a = SUM_W'(prev_rd_ff);
            alu_b = SUM_W'(neg_pen);
         end
      endcase
      alu_sum = alu_a + alu_b;
      if (alu_sum > SUM_HI) begin
         alu_in = SUM_HI[VAL_W-1:0];
      end else if (alu_sum < SUM_LO) begin
         alu_in = SUM_LO[VAL_W-1:0];
      end else begin
         alu_in = alu_sum[VAL_W-1:0];
      end
   end

   always_comb begin
      if (c1_ff >= c2_ff && c1_ff >= c3_ff) begin
         best_in = c1_ff;
         dir_in  = DIR_MATCH;
      end else if (c2_ff >= c3_ff) begin
         best_in = c2_ff;
         dir_in  = DIR_UP;
      end else begin
         best_in = c3_ff;
         dir_in  = DIR_LEFT;
      end
   end

   always_comb begin
      prev_we = 1'b0;
      prev_wa = EC'(col_ff);
      prev_wd = left_ff;
      case (state_ff)
         ST_INIT: begin
            prev_we = 1'b1;
            prev_wa = init_j_ff;
            prev_wd = init_val_ff;
         end
         ST_CELL_C: begin
            prev_we = 1'b1;
         end
         ST_CELL_D: begin
            prev_we = col_end;
            prev_wa = EC'(col_ff) + EC'(1);
            prev_wd = best_in;
         end
         default: begin
            prev_we = 1'b0;
         end
      endcase
   end

   assign prev_ra = (state_ff == ST_CELL_B) ? EC'(col_ff) + EC'(1) : EC'(col_ff);
   assign dir_wa  = DA'(row_ff) * DA'(MAX_COLS) + DA'(col_ff);
   assign dir_ra  = DA'(tb_i_ff - ER'(1)) * DA'(MAX_COLS) + DA'(tb_j_ff - EC'(1));
   assign push_in = {IDX_W'(tb_i_ff - ER'(1)),
                     (strand_ff == STRAND_DIFF) ? IDX_W'(cols_eff - tb_j_ff)
                                                : IDX_W'(tb_j_ff - EC'(1))};

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      prev_rd_ff <= prev_mem[prev_ra];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CELL_D) begin
         dir_mem[dir_wa] <= dir_in;
      end
      dir_rd_ff <= dir_mem[dir_ra];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_TB_DIR && dir_rd_ff == DIR_MATCH) begin
         stack_mem[n_ff[RW-1:0]] <= push_in;
      end
      stack_rd_ff <= stack_mem[p_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff      <= PEN_RESET;
         rows_cfg_ff <= ROWS_RESET;
         cols_cfg_ff <= COLS_RESET;
         strand_ff   <= STRAND_SAME;
      end else if (cfg_write) begin
         case (paddr[3:2])
            REG_INDEL_PENALTY:  pen_ff      <= pwdata[PEN_W-1:0];
            REG_ROWS_USED:      rows_cfg_ff <= pwdata[SIZE_W-1:0];
            REG_COLS_USED:      cols_cfg_ff <= pwdata[SIZE_W-1:0];
            REG_REVERSE_STRAND: strand_ff   <= pwdata[0];
            default:            pen_ff      <= pen_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         row_ff     <= '0;
         col_ff     <= '0;
         match_ff   <= '0;
         skip_ff    <= '0;
         left_ff    <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  score_ff <= req_score;
                  if (col_ff == '0) begin
                     left_ff <= left_in;
                  end
                  if (row_ff == '0 && col_ff == '0) begin
                     match_ff    <= '0;
                     skip_ff     <= '0;
                     init_j_ff   <= '0;
                     init_val_ff <= '0;
                     state_ff    <= ST_INIT;
                  end else begin
                     state_ff <= ST_CELL_A;
                  end
               end
            end
            ST_INIT: begin
               init_j_ff   <= init_j_ff + EC'(1);
               init_val_ff <= alu_in;
               if (init_j_ff == cols_eff) begin
                  state_ff <= ST_CELL_A;
               end
            end
            ST_CELL_A: begin
               c3_ff    <= alu_in;
               state_ff <= ST_CELL_B;
            end
            ST_CELL_B: begin
               c1_ff    <= alu_in;
               state_ff <= ST_CELL_C;
            end
            ST_CELL_C: begin
               c2_ff    <= alu_in;
               state_ff <= ST_CELL_D;
            end
            ST_CELL_D: begin
               left_ff <= best_in;
               if (col_end) begin
                  col_ff <= '0;
                  if (row_last) begin
                     row_ff   <= '0;
                     final_ff <= best_in;
                     tb_i_ff  <= rows_eff;
                     tb_j_ff  <= cols_eff;
                     n_ff     <= '0;
                     state_ff <= ST_TB_CHK;
                  end else begin
                     row_ff   <= row_ff + RW'(1);
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  col_ff   <= col_ff + CW'(1);
                  state_ff <= ST_IDLE;
               end
            end
            ST_TB_CHK: begin
               if (tb_i_ff == '0 && tb_j_ff == '0) begin
                  if (n_ff == '0) begin
                     rsp_strobe      <= 1'b1;
                     rsp_dot_valid   <= 1'b0;
                     rsp_row_index   <= '0;
                     rsp_col_index   <= '0;
                     rsp_last        <= 1'b1;
                     rsp_match_count <= match_ff;
                     rsp_skip_count  <= skip_ff;
                     rsp_final_score <= final_ff;
                     state_ff        <= ST_IDLE;
                  end else begin
                     p_ff     <= RW'(n_ff - ER'(1));
                     state_ff <= ST_EMIT_RD;
                  end
               end else if (tb_i_ff == '0) begin
                  tb_j_ff <= tb_j_ff - EC'(1);
                  skip_ff <= skip_ff + SKIP_W'(1);
               end else if (tb_j_ff == '0) begin
                  tb_i_ff <= tb_i_ff - ER'(1);
                  skip_ff <= skip_ff + SKIP_W'(1);
               end else begin
                  state_ff <= ST_TB_DIR;
               end
            end
            ST_TB_DIR: begin
               case (dir_rd_ff)
                  DIR_MATCH: begin
                     n_ff     <= n_ff + ER'(1);
                     tb_i_ff  <= tb_i_ff - ER'(1);
                     tb_j_ff  <= tb_j_ff - EC'(1);
                     match_ff <= match_ff + MATCH_W'(1);
                  end
                  DIR_UP: begin
                     tb_i_ff <= tb_i_ff - ER'(1);
                     skip_ff <= skip_ff + SKIP_W'(1);
                  end
                  default: begin
                     tb_j_ff <= tb_j_ff - EC'(1);
                     skip_ff <= skip_ff + SKIP_W'(1);
                  end
               endcase
               state_ff <= ST_TB_CHK;
            end
            ST_EMIT_RD: begin
               state_ff <= ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
               rsp_strobe      <= 1'b1;
               rsp_dot_valid   <= 1'b1;
               rsp_row_index   <= stack_rd_ff[IDX_W+OUT_IDX_W-1:IDX_W];
               rsp_col_index   <= stack_rd_ff[OUT_IDX_W-1:0];
               rsp_last        <= (p_ff == '0);
               rsp_match_count <= match_ff;
               rsp_skip_count  <= skip_ff;
               rsp_final_score <= final_ff;
               if (p_ff == '0) begin
                  state_ff <= ST_IDLE;
               end else begin
                  p_ff     <= p_ff - RW'(1);
                  state_ff <= ST_EMIT_RD;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted beat did not raise busy");

   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("non-final result beat while idle");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_dot_valid) |-> (rsp_last && rsp_match_count == '0))
      else $error("empty result beat not final or with matches");

   a_dot_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_dot_valid) |-> (rsp_match_count != '0))
      else $error("pair beat with zero match count");
`endif

endmodule
`default_nettype wire
